// ===== rtl/core/tcaoq_pkg.sv =====
package tcaoq_pkg;

	// width of the arrival stamp kept beside every stored payload
	localparam int STAMP_BITS = 6;

	localparam int DEF_QUEUE_DEPTH  = 16;
	localparam int DEF_PAYLOAD_BITS = 16;

	typedef enum logic [2:0] {
		CMD_PUSH      = 3'd0,
		CMD_POP_OLD   = 3'd1,
		CMD_POP_FIRST = 3'd2,
		CMD_POP_SECND = 3'd3,
		CMD_CLEAR     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the request fields
		logic rd;     // read both queue heads
		logic ex;     // execute the request and register the result
	} ctl_t;

endpackage

// ===== rtl/core/two_class_age_ordered_queue.sv =====
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+---------------------------
// request   | cmd, item_class, item_payload                  | taken when start & !busy
// result    | item_valid, popped_payload, popped_class,      | one cycle while done is
//           | status, all_empty                              | high, no back pressure
//
// each request passes through capture, head read and execute before the next is taken; the stores are
// synchronous-read, so both heads are read in a cycle of their own before the age compare
// done rises in the cycle after execute; busy is low then, so the next request
// may be taken in the same cycle as the previous result
// arst_n clears heads, counts, the arrival stamp and the controller; the stores need
// no clearing since only counted entries are ever used; the receiver cannot stall
module two_class_age_ordered_queue
	import tcaoq_pkg::*;
#(
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request side
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              cmd,
	input  logic                    item_class,
	input  logic [PAYLOAD_BITS-1:0] item_payload,
	// result side
	output logic                    done,
	output logic                    item_valid,
	output logic [PAYLOAD_BITS-1:0] popped_payload,
	output logic                    popped_class,
	output logic [1:0]              status,
	output logic                    all_empty
);

	// sequencing commands from the controller into the datapath
	ctl_t ctl;

	// controller: idle, head read, execute
	tcaoq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl)
	);

	// datapath: two class stores, head/count registers, arrival stamp,
	// modular age compare and the result register
	tcaoq_dp #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cmd            (cmd),
		.item_class     (item_class),
		.item_payload   (item_payload),
		.done           (done),
		.item_valid     (item_valid),
		.popped_payload (popped_payload),
		.popped_class   (popped_class),
		.status         (status),
		.all_empty      (all_empty)
	);

endmodule

// ===== rtl/core/tcaoq_ctrl.sv =====
module tcaoq_ctrl
	import tcaoq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   rd_q;
	logic   ex_q;
	logic   accept;

	assign accept = start & ~busy_q;
	assign busy   = busy_q;

	assign ctl.load = accept;
	assign ctl.rd   = rd_q;
	assign ctl.ex   = ex_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			rd_q    <= 1'b0;
			ex_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
						busy_q  <= 1'b1;
						rd_q    <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
					rd_q    <= 1'b0;
					ex_q    <= 1'b1;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					ex_q    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					rd_q    <= 1'b0;
					ex_q    <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/tcaoq_dp.sv =====
module tcaoq_dp
	import tcaoq_pkg::*;
#(
	parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_t                    ctl,
	input  logic [2:0]              cmd,
	input  logic                    item_class,
	input  logic [PAYLOAD_BITS-1:0] item_payload,
	output logic                    done,
	output logic                    item_valid,
	output logic [PAYLOAD_BITS-1:0] popped_payload,
	output logic                    popped_class,
	output logic [1:0]              status,
	output logic                    all_empty
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int ENT_W = PAYLOAD_BITS + STAMP_BITS;

	// request capture
	logic [2:0]              cmd_q;
	logic                    cls_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// queue bookkeeping
	logic [IDX_W-1:0]      head0_q, head1_q;
	logic [CNT_W-1:0]      cnt0_q, cnt1_q;
	logic [STAMP_BITS-1:0] arrival_q;

	// storage and registered head reads
	logic [ENT_W-1:0] mem0 [QUEUE_DEPTH];
	logic [ENT_W-1:0] mem1 [QUEUE_DEPTH];
	logic [ENT_W-1:0] rd0_q, rd1_q;

	// result registers
	logic                    done_q;
	logic                    valid_q;
	logic [PAYLOAD_BITS-1:0] opay_q;
	logic                    ocls_q;
	status_t                 status_q;
	logic                    empty_q;

	// execute-stage decisions
	logic                  empty0, empty1, full0, full1;
	logic                  take0, take1;
	logic                  wr0, wr1;
	logic                  push_ok;
	status_t               st_n;
	logic [STAMP_BITS-1:0] stamp_diff;
	logic [SUM_W-1:0]      tail_sum;
	logic [IDX_W-1:0]      tail;
	logic [IDX_W-1:0]      head0_inc, head1_inc;
	logic [CNT_W-1:0]      cnt0_n, cnt1_n;
	logic [IDX_W-1:0]      head0_n, head1_n;
	logic [ENT_W-1:0]      wr_entry;

	assign empty0 = (cnt0_q == '0);
	assign empty1 = (cnt1_q == '0);
	assign full0  = (cnt0_q == CNT_W'(QUEUE_DEPTH));
	assign full1  = (cnt1_q == CNT_W'(QUEUE_DEPTH));

	assign stamp_diff = rd0_q[STAMP_BITS-1:0] - rd1_q[STAMP_BITS-1:0];

	// tail of the queue being pushed
	always_comb begin
		if (cls_q) begin
			tail_sum = SUM_W'(head1_q) + SUM_W'(cnt1_q);
		end else begin
			tail_sum = SUM_W'(head0_q) + SUM_W'(cnt0_q);
		end
		if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
		end
		tail = tail_sum[IDX_W-1:0];
	end

	assign head0_inc = (head0_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head0_q + IDX_W'(1);
	assign head1_inc = (head1_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head1_q + IDX_W'(1);
	assign wr_entry  = {pay_q, arrival_q};

	always_comb begin
		take0   = 1'b0;
		take1   = 1'b0;
		wr0     = 1'b0;
		wr1     = 1'b0;
		push_ok = 1'b0;
		st_n    = ST_DONE;
		cnt0_n  = cnt0_q;
		cnt1_n  = cnt1_q;
		head0_n = head0_q;
		head1_n = head1_q;
		unique case (cmd_q)
			CMD_PUSH: begin
				if (cls_q) begin
					if (full1) st_n = ST_FULL;
					else begin
						wr1     = 1'b1;
						push_ok = 1'b1;
					end
				end else begin
					if (full0) st_n = ST_FULL;
					else begin
						wr0     = 1'b1;
						push_ok = 1'b1;
					end
				end
			end
			CMD_POP_OLD: begin
				priority if (empty0 && empty1) begin
					st_n = ST_EMPTY;
				end else if (empty0) begin
					take1 = 1'b1;
				end else if (empty1) begin
					take0 = 1'b1;
				end else if (stamp_diff[STAMP_BITS-1]) begin
					take0 = 1'b1;
				end else begin
					take1 = 1'b1;
				end
			end
			CMD_POP_FIRST: begin
				if (empty0) st_n = ST_EMPTY;
				else        take0 = 1'b1;
			end
			CMD_POP_SECND: begin
				if (empty1) st_n = ST_EMPTY;
				else        take1 = 1'b1;
			end
			CMD_CLEAR: begin
				cnt0_n  = '0;
				cnt1_n  = '0;
				head0_n = '0;
				head1_n = '0;
			end
			default: begin
				st_n = ST_DONE;
			end
		endcase
		if (wr0)   cnt0_n = cnt0_q + CNT_W'(1);
		if (wr1)   cnt1_n = cnt1_q + CNT_W'(1);
		if (take0) begin
			cnt0_n  = cnt0_q - CNT_W'(1);
			head0_n = head0_inc;
		end
		if (take1) begin
			cnt1_n  = cnt1_q - CNT_W'(1);
			head1_n = head1_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			cls_q <= item_class;
			pay_q <= item_payload;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ex && wr0) mem0[tail] <= wr_entry;
		if (ctl.rd)        rd0_q <= mem0[head0_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.ex && wr1) mem1[tail] <= wr_entry;
		if (ctl.rd)        rd1_q <= mem1[head1_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head0_q   <= '0;
			head1_q   <= '0;
			cnt0_q    <= '0;
			cnt1_q    <= '0;
			arrival_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl.ex;
			if (ctl.ex) begin
				head0_q <= head0_n;
				head1_q <= head1_n;
				cnt0_q  <= cnt0_n;
				cnt1_q  <= cnt1_n;
				if (push_ok) arrival_q <= arrival_q + STAMP_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ex) begin
			valid_q  <= take0 | take1;
			ocls_q   <= take1;
			status_q <= st_n;
			empty_q  <= (cnt0_n == '0) && (cnt1_n == '0);
			if (take0)      opay_q <= rd0_q[ENT_W-1:STAMP_BITS];
			else if (take1) opay_q <= rd1_q[ENT_W-1:STAMP_BITS];
			else            opay_q <= '0;
		end
	end

	assign done           = done_q;
	assign item_valid     = valid_q;
	assign popped_payload = opay_q;
	assign popped_class   = ocls_q;
	assign status         = status_q;
	assign all_empty      = empty_q;

endmodule
